// File: rtl/crcdf_pkg.sv
// crcdf_pkg: shared types, codes and the CRC-16/CCITT-FALSE byte update
// for the crc16_packet_deframer block. No dependencies.
package crcdf_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ByteW-1:0] SyncFirst  = 8'h55;
  localparam logic [ByteW-1:0] SyncSecond = 8'hAA;
  localparam logic [WordW-1:0] CrcInit    = 16'hFFFF;

  localparam logic [ByteW-1:0] ReadCodeRst    = 8'd0;
  localparam logic [ByteW-1:0] WriteCodeRst   = 8'd1;
  localparam logic [WordW-1:0] LengthLimitRst = 16'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_READ_CODE    = 2'd0,
    CFG_WRITE_CODE   = 2'd1,
    CFG_LENGTH_LIMIT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_GOOD      = 2'd1,
    KIND_CRC_BAD   = 2'd2,
    KIND_LEN_ABORT = 2'd3
  } kind_e;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } beat_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] payload_byte;
    logic             access_is_write;
    logic [WordW-1:0] command_word;
    logic [WordW-1:0] payload_length;
  } result_t;

  function automatic logic [WordW-1:0] crc_feed(logic [WordW-1:0] crc,
                                                logic [ByteW-1:0] b);
    logic [WordW-1:0] c;
    c = {crc[7:0], crc[15:8]};
    c = c ^ {8'h00, b};
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

  localparam logic [WordW-1:0] CrcAfterSync = crc_feed(crc_feed(CrcInit, SyncFirst), SyncSecond);

endpackage

// File: rtl/crcdf_if.sv
// crcdf_rx_if / crcdf_res_if: valid/ready channels for received bytes and
// deframer results. Depends on crcdf_pkg.
interface crcdf_rx_if;
  logic                      valid;
  logic                      ready;
  logic [crcdf_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface crcdf_res_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [crcdf_pkg::ByteW-1:0] payload_byte;
  logic                        access_is_write;
  logic [crcdf_pkg::WordW-1:0] command_word;
  logic [crcdf_pkg::WordW-1:0] payload_length;

  modport source (output valid, output kind, output payload_byte, output access_is_write,
                  output command_word, output payload_length, input ready);
  modport sink (input valid, input kind, input payload_byte, input access_is_write,
                input command_word, input payload_length, output ready);
endinterface

// File: rtl/crcdf_in_stage.sv
// crcdf_in_stage: input register for received byte beats.
// Depends on crcdf_pkg.
module crcdf_in_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [crcdf_pkg::ByteW-1:0] data_i,
  output logic                        ready_o,
  input  logic                        take_i,
  output crcdf_pkg::beat_t            beat_o
);

  logic                        valid_q;
  logic [crcdf_pkg::ByteW-1:0] data_q;

  assign ready_o = !valid_q || take_i;
  assign beat_o  = '{valid: valid_q, data: data_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

// File: rtl/crcdf_parser.sv
// crcdf_parser: frame state machine, running CRC and config registers.
// Depends on crcdf_pkg.
module crcdf_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [crcdf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [crcdf_pkg::CfgDataW-1:0] cfg_data_i,
  input  crcdf_pkg::beat_t               beat_i,
  input  logic                           space_i,
  output logic                           take_o,
  output logic                           res_valid_o,
  output crcdf_pkg::result_t             res_o
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_ACCESS, PH_CMD, PH_LEN, PH_DATA, PH_CRC
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic                        half_q, half_d;
  logic [crcdf_pkg::WordW-1:0] crc_q, crc_d;
  logic [crcdf_pkg::WordW-1:0] left_q, left_d;
  logic                        access_q, access_d;
  logic [crcdf_pkg::WordW-1:0] cmd_q, cmd_d;
  logic [crcdf_pkg::WordW-1:0] len_q, len_d;
  logic [crcdf_pkg::ByteW-1:0] crc_lo_q, crc_lo_d;

  logic [crcdf_pkg::ByteW-1:0] read_code_q, write_code_q;
  logic [crcdf_pkg::WordW-1:0] limit_q;

  logic [crcdf_pkg::ByteW-1:0] b;
  logic [crcdf_pkg::WordW-1:0] crc_fed;
  logic [crcdf_pkg::WordW-1:0] len_full;
  logic [crcdf_pkg::WordW-1:0] left_dec;
  logic [crcdf_pkg::WordW-1:0] crc_got;
  logic                        step;

  assign take_o   = beat_i.valid && space_i;
  assign step     = take_o;
  assign b        = beat_i.data;
  assign crc_fed  = crcdf_pkg::crc_feed(crc_q, b);
  assign len_full = {b, len_q[7:0]};
  assign left_dec = left_q - 16'd1;
  assign crc_got  = {b, crc_lo_q};

  always_comb begin
    phase_d     = phase_q;
    half_d      = half_q;
    crc_d       = crc_q;
    left_d      = left_q;
    access_d    = access_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    crc_lo_d    = crc_lo_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_q)
      PH_HUNT: begin
        if (half_q) begin
          half_d = 1'b0;
          if (b == crcdf_pkg::SyncSecond) begin
            crc_d   = crcdf_pkg::CrcAfterSync;
            phase_d = PH_ACCESS;
          end
        end else if (b == crcdf_pkg::SyncFirst) begin
          half_d = 1'b1;
        end
      end
      PH_ACCESS: begin
        if (b == write_code_q || b == read_code_q) begin
          access_d = (b == write_code_q);
          crc_d    = crc_fed;
          half_d   = 1'b0;
          phase_d  = PH_CMD;
        end else begin
          phase_d = PH_HUNT;
          half_d  = 1'b0;
          crc_d   = crcdf_pkg::CrcInit;
          left_d  = '0;
        end
      end
      PH_CMD: begin
        crc_d = crc_fed;
        if (!half_q) begin
          cmd_d  = {8'h00, b};
          half_d = 1'b1;
        end else begin
          cmd_d   = {b, cmd_q[7:0]};
          half_d  = 1'b0;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        crc_d = crc_fed;
        if (!half_q) begin
          len_d  = {8'h00, b};
          half_d = 1'b1;
        end else begin
          len_d  = len_full;
          half_d = 1'b0;
          if (len_full >= limit_q) begin
            res_valid_o           = 1'b1;
            res_o.kind            = crcdf_pkg::KIND_LEN_ABORT;
            res_o.access_is_write = access_q;
            res_o.command_word    = cmd_q;
            res_o.payload_length  = len_full;
            phase_d = PH_HUNT;
            crc_d   = crcdf_pkg::CrcInit;
            left_d  = '0;
          end else begin
            left_d  = len_full;
            phase_d = (len_full == '0) ? PH_CRC : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        crc_d  = crc_fed;
        left_d = left_dec;
        if (left_dec == '0) begin
          phase_d = PH_CRC;
          half_d  = 1'b0;
        end
        res_valid_o        = 1'b1;
        res_o.kind         = crcdf_pkg::KIND_PAYLOAD;
        res_o.payload_byte = b;
      end
      PH_CRC: begin
        if (!half_q) begin
          crc_lo_d = b;
          half_d   = 1'b1;
        end else begin
          res_valid_o           = 1'b1;
          res_o.kind            = (crc_got == crc_q) ? crcdf_pkg::KIND_GOOD
                                                     : crcdf_pkg::KIND_CRC_BAD;
          res_o.access_is_write = access_q;
          res_o.command_word    = cmd_q;
          res_o.payload_length  = len_q;
          phase_d = PH_HUNT;
          half_d  = 1'b0;
          crc_d   = crcdf_pkg::CrcInit;
          left_d  = '0;
        end
      end
      default: begin
        phase_d = PH_HUNT;
        half_d  = 1'b0;
        crc_d   = crcdf_pkg::CrcInit;
        left_d  = '0;
      end
    endcase
    if (!step) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      half_q   <= 1'b0;
      crc_q    <= crcdf_pkg::CrcInit;
      left_q   <= '0;
      access_q <= 1'b0;
      cmd_q    <= '0;
      len_q    <= '0;
      crc_lo_q <= '0;
    end else if (step) begin
      phase_q  <= phase_d;
      half_q   <= half_d;
      crc_q    <= crc_d;
      left_q   <= left_d;
      access_q <= access_d;
      cmd_q    <= cmd_d;
      len_q    <= len_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_code_q  <= crcdf_pkg::ReadCodeRst;
      write_code_q <= crcdf_pkg::WriteCodeRst;
      limit_q      <= crcdf_pkg::LengthLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        crcdf_pkg::CFG_READ_CODE:    read_code_q  <= cfg_data_i[7:0];
        crcdf_pkg::CFG_WRITE_CODE:   write_code_q <= cfg_data_i[7:0];
        crcdf_pkg::CFG_LENGTH_LIMIT: limit_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/crcdf_out_stage.sv
// crcdf_out_stage: result register between the parser and the consumer.
// Depends on crcdf_pkg.
module crcdf_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  crcdf_pkg::result_t res_i,
  output logic               space_o,
  output logic               valid_o,
  input  logic               ready_i,
  output crcdf_pkg::result_t res_o
);

  logic               valid_q;
  crcdf_pkg::result_t res_q;

  assign space_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// File: rtl/crc16_packet_deframer.sv
// crc16_packet_deframer: sync hunt, header capture, payload streaming, CRC-16 check.
// Each result is registered: a byte beat passes the input register, then parse
// logic into the result register. Throughput: one byte beat per cycle while the
// result consumer does not stall, limited by the combinational CRC byte update.
// Reset: asynchronous, active low; returns to sync hunt, CRC at 0xFFFF, config defaults.
// Depends on crcdf_pkg, crcdf_if, crcdf_in_stage, crcdf_parser, crcdf_out_stage.
module crc16_packet_deframer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [crcdf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [crcdf_pkg::CfgDataW-1:0] cfg_data_i,
  crcdf_rx_if.sink                       rx_i,
  crcdf_res_if.source                    res_o
);

  crcdf_pkg::beat_t   beat;
  crcdf_pkg::result_t res_next;
  crcdf_pkg::result_t res_reg;
  logic               take;
  logic               space;
  logic               res_next_valid;

  crcdf_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rx_i.valid),
    .data_i  (rx_i.rx_byte),
    .ready_o (rx_i.ready),
    .take_i  (take),
    .beat_o  (beat)
  );

  crcdf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .beat_i      (beat),
    .space_i     (space),
    .take_o      (take),
    .res_valid_o (res_next_valid),
    .res_o       (res_next)
  );

  crcdf_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (res_next_valid),
    .res_i   (res_next),
    .space_o (space),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .res_o   (res_reg)
  );

  assign res_o.kind            = res_reg.kind;
  assign res_o.payload_byte    = res_reg.payload_byte;
  assign res_o.access_is_write = res_reg.access_is_write;
  assign res_o.command_word    = res_reg.command_word;
  assign res_o.payload_length  = res_reg.payload_length;

endmodule

// File: rtl/crcdf_checker.sv
// crcdf_checker: port-level assertions for crc16_packet_deframer, with bind.
// Depends on crcdf_pkg and crc16_packet_deframer.
module crcdf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [1:0]                  kind_i,
  input logic [crcdf_pkg::ByteW-1:0] payload_byte_i,
  input logic                        access_is_write_i,
  input logic [crcdf_pkg::WordW-1:0] command_word_i,
  input logic [crcdf_pkg::WordW-1:0] payload_length_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(payload_byte_i)
      && $stable(command_word_i) && $stable(payload_length_i) && $stable(access_is_write_i))
    else $error("result changed while stalled");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == crcdf_pkg::KIND_PAYLOAD |->
      !access_is_write_i && command_word_i == '0 && payload_length_i == '0)
    else $error("payload beat carries header fields");

  a_closing_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != crcdf_pkg::KIND_PAYLOAD |-> payload_byte_i == '0)
    else $error("closing beat carries a payload byte");

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind crc16_packet_deframer crcdf_checker u_crcdf_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (res_o.valid),
  .out_ready_i       (res_o.ready),
  .kind_i            (res_o.kind),
  .payload_byte_i    (res_o.payload_byte),
  .access_is_write_i (res_o.access_is_write),
  .command_word_i    (res_o.command_word),
  .payload_length_i  (res_o.payload_length)
);

// File: tb/sv/crc16_packet_deframer_tb.sv
// crc16_packet_deframer_tb: self-checking bench for the CRC-16 packet deframer.
// Drives byte beats through crcdf_rx_if, checks results on crcdf_res_if against
// a local frame decoder. Depends on crcdf_pkg, crcdf_if and the deframer RTL.
module crc16_packet_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit    = 500000;
  localparam int          DrainCycles   = 8;
  localparam int          HoldCycles    = 150;
  localparam int          PhaseBeats    = 204;
  localparam int          NumPhases     = 8;
  localparam logic [15:0] CrcPoly       = 16'h1021;

  typedef enum logic [2:0] {
    ST_HUNT, ST_ACCESS, ST_CMD, ST_LEN, ST_DATA, ST_CRC
  } parse_state_e;

  typedef enum logic [1:0] {ROW_DATA, ROW_CRC_LO, ROW_CRC_HI} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [7:0]          data;
    bit                  typed;
    crcdf_pkg::result_t  want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [crcdf_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [crcdf_pkg::CfgDataW-1:0] cfg_data_i;

  crcdf_rx_if  rx_bus();
  crcdf_res_if res_bus();

  crc16_packet_deframer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_i       (rx_bus),
    .res_o      (res_bus)
  );

  always #2 clk_i = ~clk_i;

  // decoder state and register copies
  logic [7:0]   cfg_read_code  = crcdf_pkg::ReadCodeRst;
  logic [7:0]   cfg_write_code = crcdf_pkg::WriteCodeRst;
  logic [15:0]  cfg_len_limit  = crcdf_pkg::LengthLimitRst;
  parse_state_e frame_state    = ST_HUNT;
  logic         pair_half      = 1'b0;
  logic [15:0]  frame_crc      = crcdf_pkg::CrcInit;
  logic [15:0]  bytes_to_go    = '0;
  logic         frame_is_write = 1'b0;
  logic [15:0]  frame_cmd      = '0;
  logic [15:0]  frame_len      = '0;
  logic [7:0]   crc_lo_rx      = '0;

  crcdf_pkg::result_t pending_results[$];
  int n_errors = 0;
  int n_beats = 0;
  int n_checked = 0;
  int n_payload = 0;
  int n_good = 0;
  int n_crc_bad = 0;
  int n_abort = 0;
  int n_settings = 1;
  int big_frames_left = 2;
  int burst_left[2] = '{0, 0};
  bit hold_pending = 1'b0;
  int unsigned cycle_count = 0;

  dir_row_t dir_rows [24] = '{
    // broken sync pair: second 0x55 is eaten, lone 0xAA ignored
    '{ROW_DATA, 8'h55, 1'b0, '0},
    '{ROW_DATA, 8'h55, 1'b0, '0},
    '{ROW_DATA, 8'hAA, 1'b0, '0},
    // sync, then an access byte matching neither code
    '{ROW_DATA, 8'h55, 1'b0, '0},
    '{ROW_DATA, 8'hAA, 1'b0, '0},
    '{ROW_DATA, 8'h07, 1'b0, '0},
    // length equal to the reset limit aborts
    '{ROW_DATA, 8'h55, 1'b0, '0},
    '{ROW_DATA, 8'hAA, 1'b0, '0},
    '{ROW_DATA, 8'h01, 1'b0, '0},
    '{ROW_DATA, 8'h34, 1'b0, '0},
    '{ROW_DATA, 8'h12, 1'b0, '0},
    '{ROW_DATA, 8'hFF, 1'b0, '0},
    '{ROW_DATA, 8'h00, 1'b1,
      '{crcdf_pkg::KIND_LEN_ABORT, 8'h00, 1'b1, 16'h1234, 16'h00FF}},
    // read frame, command 0xFFFF, payload 00 FF, good CRC
    '{ROW_DATA, 8'h55, 1'b0, '0},
    '{ROW_DATA, 8'hAA, 1'b0, '0},
    '{ROW_DATA, 8'h00, 1'b0, '0},
    '{ROW_DATA, 8'hFF, 1'b0, '0},
    '{ROW_DATA, 8'hFF, 1'b0, '0},
    '{ROW_DATA, 8'h02, 1'b0, '0},
    '{ROW_DATA, 8'h00, 1'b0, '0},
    '{ROW_DATA, 8'h00, 1'b1,
      '{crcdf_pkg::KIND_PAYLOAD, 8'h00, 1'b0, 16'h0000, 16'h0000}},
    '{ROW_DATA, 8'hFF, 1'b1,
      '{crcdf_pkg::KIND_PAYLOAD, 8'hFF, 1'b0, 16'h0000, 16'h0000}},
    '{ROW_CRC_LO, 8'h00, 1'b0, '0},
    '{ROW_CRC_HI, 8'h00, 1'b0, '0}
  };

  function automatic logic [15:0] crc16_next(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ((r << 1) ^ CrcPoly) : (r << 1);
    end
    return r;
  endfunction

  function automatic void back_to_hunt();
    frame_state = ST_HUNT;
    pair_half   = 1'b0;
    frame_crc   = crcdf_pkg::CrcInit;
    bytes_to_go = '0;
  endfunction

  function automatic crcdf_pkg::result_t closing(crcdf_pkg::kind_e k);
    crcdf_pkg::result_t r;
    r = '0;
    r.kind            = k;
    r.access_is_write = frame_is_write;
    r.command_word    = frame_cmd;
    r.payload_length  = frame_len;
    return r;
  endfunction

  function automatic void frame_decode(input logic [7:0] b, output bit has,
                                       output crcdf_pkg::result_t r);
    has = 1'b0;
    r   = '0;
    case (frame_state)
      ST_HUNT: begin
        if (pair_half) begin
          pair_half = 1'b0;
          if (b == crcdf_pkg::SyncSecond) begin
            frame_crc   = crc16_next(crc16_next(crcdf_pkg::CrcInit, crcdf_pkg::SyncFirst),
                                     crcdf_pkg::SyncSecond);
            frame_state = ST_ACCESS;
          end
        end else if (b == crcdf_pkg::SyncFirst) begin
          pair_half = 1'b1;
        end
      end
      ST_ACCESS: begin
        if (b == cfg_write_code || b == cfg_read_code) begin
          frame_is_write = (b == cfg_write_code);
          frame_crc      = crc16_next(frame_crc, b);
          pair_half      = 1'b0;
          frame_state    = ST_CMD;
        end else begin
          back_to_hunt();
        end
      end
      ST_CMD: begin
        frame_crc = crc16_next(frame_crc, b);
        if (!pair_half) begin
          frame_cmd = {8'h00, b};
          pair_half = 1'b1;
        end else begin
          frame_cmd[15:8] = b;
          pair_half       = 1'b0;
          frame_state     = ST_LEN;
        end
      end
      ST_LEN: begin
        frame_crc = crc16_next(frame_crc, b);
        if (!pair_half) begin
          frame_len = {8'h00, b};
          pair_half = 1'b1;
        end else begin
          frame_len[15:8] = b;
          pair_half       = 1'b0;
          if (frame_len >= cfg_len_limit) begin
            has = 1'b1;
            r   = closing(crcdf_pkg::KIND_LEN_ABORT);
            back_to_hunt();
          end else begin
            bytes_to_go = frame_len;
            frame_state = (frame_len == 16'd0) ? ST_CRC : ST_DATA;
          end
        end
      end
      ST_DATA: begin
        frame_crc   = crc16_next(frame_crc, b);
        bytes_to_go = bytes_to_go - 16'd1;
        if (bytes_to_go == 16'd0) begin
          frame_state = ST_CRC;
          pair_half   = 1'b0;
        end
        has            = 1'b1;
        r.kind         = crcdf_pkg::KIND_PAYLOAD;
        r.payload_byte = b;
      end
      ST_CRC: begin
        if (!pair_half) begin
          crc_lo_rx = b;
          pair_half = 1'b1;
        end else begin
          has = 1'b1;
          r   = closing(({b, crc_lo_rx} == frame_crc) ? crcdf_pkg::KIND_GOOD
                                                      : crcdf_pkg::KIND_CRC_BAD);
          back_to_hunt();
        end
      end
      default: back_to_hunt();
    endcase
  endfunction

  // side 0: sender, side 1: receiver; occasional stretches with no gaps
  function automatic int draw_gap(int side);
    if (burst_left[side] > 0) begin
      burst_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left[side] = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input crcdf_pkg::result_t want);
    int gap;
    bit has;
    crcdf_pkg::result_t got;
    gap = draw_gap(0);
    if (gap > 0) begin
      rx_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    do @(posedge clk_i); while (!rx_bus.ready);
    n_beats++;
    frame_decode(b, has, got);
    if (typed) pending_results.push_back(want);
    else if (has) pending_results.push_back(got);
  endtask

  task automatic send_frame();
    int lim;
    int cap;
    int len;
    logic [7:0]  b;
    logic [15:0] cmd;
    logic [15:0] crc_sent;
    lim = int'(cfg_len_limit);
    if ($urandom_range(0, 99) < 72) begin
      send_byte(crcdf_pkg::SyncFirst, 1'b0, '0);
      send_byte(crcdf_pkg::SyncSecond, 1'b0, '0);
      send_byte($urandom_range(0, 1) ? cfg_write_code : cfg_read_code, 1'b0, '0);
      cmd = 16'($urandom_range(0, 65535));
      send_byte(cmd[7:0], 1'b0, '0);
      send_byte(cmd[15:8], 1'b0, '0);
      cap = (lim - 1 < 24) ? lim - 1 : 24;
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(lim, 65535);
      end else if (big_frames_left > 0 && lim > 300 && $urandom_range(0, 19) == 0) begin
        len = 300;
        big_frames_left--;
      end else begin
        len = $urandom_range(0, cap);
      end
      send_byte(len[7:0], 1'b0, '0);
      send_byte(len[15:8], 1'b0, '0);
      if (len >= lim) return;
      repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      crc_sent = frame_crc;
      if ($urandom_range(0, 6) == 0) crc_sent ^= 16'($urandom_range(1, 65535));
      send_byte(crc_sent[7:0], 1'b0, '0);
      send_byte(crc_sent[15:8], 1'b0, '0);
    end else begin
      case ($urandom_range(0, 2))
        0: repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        1: begin
          b = 8'($urandom_range(0, 254));
          if (b >= crcdf_pkg::SyncSecond) b++;
          send_byte(crcdf_pkg::SyncFirst, 1'b0, '0);
          send_byte(b, 1'b0, '0);
        end
        default: begin
          do b = 8'($urandom_range(0, 255));
          while (b == cfg_read_code || b == cfg_write_code);
          send_byte(crcdf_pkg::SyncFirst, 1'b0, '0);
          send_byte(crcdf_pkg::SyncSecond, 1'b0, '0);
          send_byte(b, 1'b0, '0);
        end
      endcase
    end
  endtask

  task automatic drain_idle();
    rx_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input crcdf_pkg::cfg_idx_e idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      crcdf_pkg::CFG_READ_CODE:    cfg_read_code  = val[7:0];
      crcdf_pkg::CFG_WRITE_CODE:   cfg_write_code = val[7:0];
      crcdf_pkg::CFG_LENGTH_LIMIT: cfg_len_limit  = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [7:0] rd, input logic [7:0] wr,
                              input logic [15:0] lim);
    write_reg(crcdf_pkg::CFG_READ_CODE, {8'h00, rd});
    write_reg(crcdf_pkg::CFG_WRITE_CODE, {8'h00, wr});
    write_reg(crcdf_pkg::CFG_LENGTH_LIMIT, lim);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  task automatic check_result();
    crcdf_pkg::result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kind %0d byte 0x%0h",
               $time, res_bus.kind, res_bus.payload_byte);
      n_errors++;
      return;
    end
    want = pending_results.pop_front();
    n_checked++;
    compare_field("kind", want.kind, res_bus.kind);
    compare_field("payload_byte", want.payload_byte, res_bus.payload_byte);
    compare_field("access_is_write", want.access_is_write, res_bus.access_is_write);
    compare_field("command_word", want.command_word, res_bus.command_word);
    compare_field("payload_length", want.payload_length, res_bus.payload_length);
    case (crcdf_pkg::kind_e'(res_bus.kind))
      crcdf_pkg::KIND_PAYLOAD: n_payload++;
      crcdf_pkg::KIND_GOOD:    n_good++;
      crcdf_pkg::KIND_CRC_BAD: n_crc_bad++;
      default:                 n_abort++;
    endcase
  endtask

  // result sink with random back-pressure and one long hold
  initial begin
    int gap;
    res_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        gap = HoldCycles;
      end else begin
        gap = draw_gap(1);
      end
      if (gap > 0) begin
        res_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!res_bus.valid);
      check_result();
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int phase_start;
    logic [15:0] lim;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = crcdf_pkg::CFG_READ_CODE;
    cfg_data_i     = '0;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CRC_LO: send_byte(frame_crc[7:0], 1'b0, '0);
        ROW_CRC_HI: send_byte(frame_crc[15:8], 1'b0, '0);
        default:    send_byte(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
      endcase
    end
    drain_idle();

    for (int p = 1; p <= NumPhases; p++) begin
      case (p)
        1: apply_config(8'hFF, 8'h00, 16'd1);
        2: apply_config(8'hFF, 8'hFF, 16'hFFFF);
        default: begin
          lim = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                            : 16'($urandom_range(1, 30));
          apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), lim);
        end
      endcase
      if (p == 3) hold_pending = 1'b1;
      phase_start = n_beats;
      while (n_beats - phase_start < PhaseBeats) send_frame();
      drain_idle();
    end

    $display("Sent %0d byte beats under %0d register settings; checked %0d results:",
             n_beats, n_settings, n_checked);
    $display("  %0d payload bytes, %0d good frames, %0d CRC errors, %0d length aborts",
             n_payload, n_good, n_crc_bad, n_abort);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
